// File: src/ffa_pkg.sv
// Shared codes for the first-fit contiguous block allocator.
package ffa_pkg;

  // Request operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_SPACE   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd4;
  localparam logic [2:0] ST_DUPLICATE  = 3'd5;

  // Widths of the fixed port fields
  localparam int unsigned BLK_OUT_W = 10;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned LEN_W     = 11;

endpackage

// File: src/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/first_fit_contiguous_block_allocator_core.sv
// Top level of the first-fit contiguous block allocator.
//
// Input channel (in_valid_i/in_ready_o) carries one request: op_i, file_id_i
// and length_i. Output channel (out_valid_o/out_ready_i) returns exactly one
// result per request: status, block range and the free/used counts after it.
// One request is in flight at a time; in_ready_o is high only when idle.
// A query, the spare op code or a zero-length alloc goes straight to the result.
// Free and alloc first walk the file table; a free that hits then clears its
// range, and an alloc that is not turned away scans the bitmap and marks the
// run that it finds.
// The bitmap walk goes one block per cycle through the single RAM port,
// and the file table is walked one entry per cycle.
// After reset, and after every disk_blocks write (cfg_we_i), a clearing
// pass writes the bitmap one block per cycle over all disk_blocks blocks; no
// request is accepted until it ends. Table valid bits clear at once.
// A stalled receiver holds the result in the output register; the block
// takes no new request until the result is taken.
module first_fit_contiguous_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS    = 1024,
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned FILE_ID_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  file_id_i,
  input  logic [10:0] length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [9:0]  start_block_o,
  output logic [9:0]  end_block_o,
  output logic [10:0] free_blocks_o,
  output logic [10:0] used_blocks_o
);

  localparam int unsigned AW  = MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LW  = CW > ffa_pkg::LEN_W ? CW : ffa_pkg::LEN_W;
  localparam int unsigned TW  = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned IDW = FILE_ID_BITS;
  localparam int unsigned DISK_RST = MAX_BLOCKS < 1024 ? MAX_BLOCKS : 1024;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TSCAN = 3'd2;
  localparam logic [2:0] S_BSCAN = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] disk_q, disk_d;
  logic [CW-1:0] free_q, free_d;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic          pv_q, pv_d;
  logic [LW-1:0] run_q, run_d;
  logic [1:0]    op_q, op_d;
  logic [IDW-1:0] id_q, id_d;
  logic [LW-1:0] len_q, len_d;
  logic [TW-1:0] tidx_q, tidx_d;
  logic          hit_q, hit_d;
  logic [TW-1:0] hidx_q, hidx_d;
  logic          slot_ok_q, slot_ok_d;
  logic [TW-1:0] slot_q, slot_d;
  logic [AW-1:0] s_q, s_d;
  logic [AW-1:0] e_q, e_d;
  logic [2:0]    status_q, status_d;
  logic          mval_q, mval_d;

  // File table: valid bits in flops, entry fields as plain registers
  logic [TABLE_ENTRIES-1:0] tvalid_q, tvalid_d;
  logic [IDW-1:0] tid_q    [TABLE_ENTRIES];
  logic [AW-1:0]  tstart_q [TABLE_ENTRIES];
  logic [AW-1:0]  tend_q   [TABLE_ENTRIES];
  logic           twe;

  // Bitmap RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  logic [10:0]   cfg_v;
  logic [LW-1:0] run_nx;
  logic [CW-1:0] nblk;

  ffa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BLOCKS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // RAM port drive: clearing pass writes 0, marking writes the mark value
  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_MARK);
  assign ram_waddr = cnt_q[AW-1:0];
  assign ram_wdata = (state_q == S_MARK) ? mval_q : 1'b0;
  assign ram_raddr = cnt_q[AW-1:0];

  assign run_nx = ram_rdata ? '0 : run_q + LW'(1);
  assign nblk   = CW'(e_q) - CW'(s_q) + CW'(1);

  // A written disk size of zero is taken as one; the MAX_BLOCKS clamp is in the size write
  always_comb begin
    cfg_v = cfg_wdata_i;
    if (cfg_v == 11'd0) begin
      cfg_v = 11'd1;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    disk_d    = disk_q;
    free_d    = free_q;
    used_d    = used_q;
    cnt_d     = cnt_q;
    pidx_d    = pidx_q;
    pv_d      = 1'b0;
    run_d     = run_q;
    op_d      = op_q;
    id_d      = id_q;
    len_d     = len_q;
    tidx_d    = tidx_q;
    hit_d     = hit_q;
    hidx_d    = hidx_q;
    slot_ok_d = slot_ok_q;
    slot_d    = slot_q;
    s_d       = s_q;
    e_d       = e_q;
    status_d  = status_q;
    mval_d    = mval_q;
    tvalid_d  = tvalid_q;
    twe       = 1'b0;

    case (state_q)
      S_CLEAR: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == disk_q - CW'(1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_i;
          id_d      = IDW'(file_id_i);
          len_d     = LW'(length_i);
          tidx_d    = '0;
          hit_d     = 1'b0;
          slot_ok_d = 1'b0;
          s_d       = '0;
          e_d       = '0;
          status_d  = ffa_pkg::ST_OK;
          if (op_i == ffa_pkg::OP_ALLOC && length_i == 11'd0) begin
            status_d = ffa_pkg::ST_BAD_LENGTH;
            state_d  = S_DONE;
          end else if (op_i == ffa_pkg::OP_ALLOC || op_i == ffa_pkg::OP_FREE) begin
            state_d = S_TSCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_TSCAN: begin
        // One table entry per cycle: id match and first empty slot
        if (tvalid_q[tidx_q] && tid_q[tidx_q] == id_q && !hit_q) begin
          hit_d  = 1'b1;
          hidx_d = tidx_q;
        end
        if (!tvalid_q[tidx_q] && !slot_ok_q) begin
          slot_ok_d = 1'b1;
          slot_d    = tidx_q;
        end
        tidx_d = tidx_q + TW'(1);
        if (32'(tidx_q) == TABLE_ENTRIES - 1) begin
          state_d = S_DONE;
          if (op_q == ffa_pkg::OP_ALLOC) begin
            if (hit_d) begin
              status_d = ffa_pkg::ST_DUPLICATE;
            end else if (!slot_ok_d) begin
              status_d = ffa_pkg::ST_TABLE_FULL;
            end else begin
              cnt_d   = '0;
              run_d   = '0;
              state_d = S_BSCAN;
            end
          end else if (!hit_d) begin
            status_d = ffa_pkg::ST_NOT_FOUND;
          end else begin
            s_d     = tstart_q[hidx_d];
            e_d     = tend_q[hidx_d];
            cnt_d   = CW'(tstart_q[hidx_d]);
            mval_d  = 1'b0;
            state_d = S_MARK;
          end
        end
      end
      S_BSCAN: begin
        // Issue one read per cycle, evaluate the block read last cycle
        if (cnt_q < disk_q) begin
          pv_d   = 1'b1;
          pidx_d = cnt_q[AW-1:0];
          cnt_d  = cnt_q + CW'(1);
        end
        if (pv_q) begin
          run_d = run_nx;
          if (!ram_rdata && run_nx >= len_q) begin
            e_d     = pidx_q;
            s_d     = AW'(LW'(pidx_q) + LW'(1) - len_q);
            cnt_d   = CW'(AW'(LW'(pidx_q) + LW'(1) - len_q));
            pv_d    = 1'b0;
            mval_d  = 1'b1;
            state_d = S_MARK;
          end else if (CW'(pidx_q) == disk_q - CW'(1)) begin
            status_d = ffa_pkg::ST_NO_SPACE;
            pv_d     = 1'b0;
            state_d  = S_DONE;
          end
        end
      end
      S_MARK: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q[AW-1:0] == e_q) begin
          state_d = S_DONE;
          if (mval_q) begin
            twe              = 1'b1;
            tvalid_d[slot_q] = 1'b1;
            free_d           = free_q - nblk;
            used_d           = used_q + nblk;
          end else begin
            tvalid_d[hidx_q] = 1'b0;
            free_d           = free_q + nblk;
            used_d           = used_q - nblk;
          end
        end
      end
      S_DONE: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Size write: restart the disk with a clearing pass
    if (cfg_we_i) begin
      if (32'(cfg_v) > MAX_BLOCKS) begin
        disk_d = CW'(MAX_BLOCKS);
      end else begin
        disk_d = CW'(cfg_v);
      end
      free_d   = disk_d;
      used_d   = '0;
      tvalid_d = '0;
      cnt_d    = '0;
      state_d  = S_CLEAR;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      disk_q   <= CW'(DISK_RST);
      free_q   <= CW'(DISK_RST);
      used_q   <= '0;
      cnt_q    <= '0;
      pv_q     <= 1'b0;
      tvalid_q <= '0;
    end else begin
      state_q  <= state_d;
      disk_q   <= disk_d;
      free_q   <= free_d;
      used_q   <= used_d;
      cnt_q    <= cnt_d;
      pv_q     <= pv_d;
      tvalid_q <= tvalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pidx_q    <= pidx_d;
    run_q     <= run_d;
    op_q      <= op_d;
    id_q      <= id_d;
    len_q     <= len_d;
    tidx_q    <= tidx_d;
    hit_q     <= hit_d;
    hidx_q    <= hidx_d;
    slot_ok_q <= slot_ok_d;
    slot_q    <= slot_d;
    s_q       <= s_d;
    e_q       <= e_d;
    status_q  <= status_d;
    mval_q    <= mval_d;
    if (twe) begin
      tid_q[slot_q]    <= id_q;
      tstart_q[slot_q] <= s_q;
      tend_q[slot_q]   <= e_q;
    end
  end

  // Outputs
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_DONE);
  assign status_o      = status_q;
  assign start_block_o = ffa_pkg::BLK_OUT_W'(s_q);
  assign end_block_o   = ffa_pkg::BLK_OUT_W'(e_q);
  assign free_blocks_o = ffa_pkg::CNT_OUT_W'(free_q);
  assign used_blocks_o = ffa_pkg::CNT_OUT_W'(used_q);

  // Free and used counts always cover the whole disk
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q + used_q) == disk_q)
    else $error("free plus used count differs from disk size");

  // Marking never runs past the range end
  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK) |-> (cnt_q[AW-1:0] <= e_q))
    else $error("mark counter beyond range end");

  // Accepted request never yields a result in the same cycle
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready and result valid at once");

  // A taken result returns the block to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !cfg_we_i) |=> in_ready_o)
    else $error("block not idle after result taken");

endmodule

// File: tb/tb.sv
// Testbench for the first-fit contiguous block allocator: directed table plus random requests.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_BLK    = 1024;
  localparam int unsigned TBL_SLOTS  = 32;
  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam int unsigned HOLD_CYCLES = 300;

  // Op code with no operation of its own; the block treats it as a query
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  start_blk;
    logic [9:0]  end_blk;
    logic [10:0] free_blk;
    logic [10:0] used_blk;
  } alloc_result_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [7:0]    file_id;
    logic [10:0]   length;
    logic          typed;
    alloc_result_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [7:0]  file_id_i = '0;
  logic [10:0] length_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [9:0]  start_block_o;
  logic [9:0]  end_block_o;
  logic [10:0] free_blocks_o;
  logic [10:0] used_blocks_o;

  first_fit_contiguous_block_allocator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .file_id_i     (file_id_i),
    .length_i      (length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .start_block_o (start_block_o),
    .end_block_o   (end_block_o),
    .free_blocks_o (free_blocks_o),
    .used_blocks_o (used_blocks_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the allocator state
  bit          blk_used [MAX_BLK];
  bit          ent_valid [TBL_SLOTS];
  logic [7:0]  ent_id [TBL_SLOTS];
  int unsigned ent_start [TBL_SLOTS];
  int unsigned ent_end [TBL_SLOTS];
  int unsigned disk_size;
  int unsigned free_cnt;
  int unsigned used_cnt;

  alloc_result_t pending_results [$];
  int unsigned   fail_cnt = 0;
  int unsigned   cycle_cnt = 0;
  bit            idle_en = 1'b1;
  bit            hold_req = 1'b0;

  // Disk size write: clamps, then wipes bitmap and file table
  function automatic void set_disk_size(logic [10:0] val);
    int unsigned v;
    v = val;
    if (v < 1) v = 1;
    if (v > MAX_BLK) v = MAX_BLK;
    disk_size = v;
    foreach (blk_used[i]) blk_used[i] = 1'b0;
    foreach (ent_valid[i]) ent_valid[i] = 1'b0;
    free_cnt = v;
    used_cnt = 0;
  endfunction

  function automatic int find_file(logic [7:0] id);
    for (int i = 0; i < TBL_SLOTS; i++) begin
      if (ent_valid[i] && ent_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Expected result of one request, updating the shadow state
  function automatic alloc_result_t apply_request(logic [1:0] op, logic [7:0] id,
                                                  logic [10:0] len);
    alloc_result_t r;
    int hit;
    int slot;
    int unsigned run;
    int unsigned last;
    bit found;
    r = '0;
    r.status = ffa_pkg::ST_OK;
    hit = find_file(id);
    if (op == ffa_pkg::OP_ALLOC) begin
      slot = -1;
      for (int i = TBL_SLOTS - 1; i >= 0; i--) begin
        if (!ent_valid[i]) slot = i;
      end
      if (len == 0) r.status = ffa_pkg::ST_BAD_LENGTH;
      else if (hit >= 0) r.status = ffa_pkg::ST_DUPLICATE;
      else if (slot < 0) r.status = ffa_pkg::ST_TABLE_FULL;
      else begin
        // first fit: lowest run of free blocks long enough
        run = 0;
        found = 1'b0;
        last = 0;
        for (int unsigned b = 0; b < disk_size && !found; b++) begin
          if (blk_used[b]) run = 0;
          else begin
            run++;
            if (run >= len) begin
              found = 1'b1;
              last = b;
            end
          end
        end
        if (!found) r.status = ffa_pkg::ST_NO_SPACE;
        else begin
          for (int unsigned b = last + 1 - len; b <= last; b++) blk_used[b] = 1'b1;
          ent_valid[slot] = 1'b1;
          ent_id[slot] = id;
          ent_start[slot] = last + 1 - len;
          ent_end[slot] = last;
          free_cnt -= len;
          used_cnt += len;
          r.start_blk = 10'(last + 1 - len);
          r.end_blk = 10'(last);
        end
      end
    end else if (op == ffa_pkg::OP_FREE) begin
      if (hit < 0) r.status = ffa_pkg::ST_NOT_FOUND;
      else begin
        for (int unsigned b = ent_start[hit]; b <= ent_end[hit]; b++) blk_used[b] = 1'b0;
        ent_valid[hit] = 1'b0;
        free_cnt += ent_end[hit] - ent_start[hit] + 1;
        used_cnt -= ent_end[hit] - ent_start[hit] + 1;
        r.start_blk = 10'(ent_start[hit]);
        r.end_blk = 10'(ent_end[hit]);
      end
    end
    r.free_blk = 11'(free_cnt);
    r.used_blk = 11'(used_cnt);
    return r;
  endfunction

  // Offer one request and record its expected result at acceptance
  task automatic issue_request(logic [1:0] op, logic [7:0] id, logic [10:0] len,
                               bit typed, alloc_result_t want);
    alloc_result_t got;
    if (idle_en && $urandom_range(0, 99) < 35) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    file_id_i <= id;
    length_i <= len;
    do @(posedge clk_i); while (!in_ready_o);
    got = apply_request(op, id, len);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_disk_size(logic [10:0] val);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    set_disk_size(val);
  endtask

  // Random requests: mostly allocates and frees over an id pool of 0..id_hi
  task automatic random_phase(int unsigned n, int unsigned id_hi, int unsigned len_hi);
    int unsigned pick;
    logic [1:0]  op;
    logic [10:0] len;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) op = ffa_pkg::OP_ALLOC;
      else if (pick < 88) op = ffa_pkg::OP_FREE;
      else if (pick < 95) op = ffa_pkg::OP_QUERY;
      else op = OP_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 4) len = '0;
      else if (pick < 9) len = 11'($urandom_range(0, 2047));
      else len = 11'($urandom_range(1, len_hi));
      issue_request(op, 8'($urandom_range(0, id_hi)), len, 1'b0, '0);
    end
  endtask

  // Result checker and ready driver
  initial begin
    alloc_result_t exp_res;
    int unsigned   hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt++;
        end else begin
          exp_res = pending_results.pop_front();
          if (status_o !== exp_res.status) begin
            $error("status exp %0d got %0d", exp_res.status, status_o);
            fail_cnt++;
          end
          if (start_block_o !== exp_res.start_blk) begin
            $error("start_block exp %0d got %0d", exp_res.start_blk, start_block_o);
            fail_cnt++;
          end
          if (end_block_o !== exp_res.end_blk) begin
            $error("end_block exp %0d got %0d", exp_res.end_blk, end_block_o);
            fail_cnt++;
          end
          if (free_blocks_o !== exp_res.free_blk) begin
            $error("free_blocks exp %0d got %0d", exp_res.free_blk, free_blocks_o);
            fail_cnt++;
          end
          if (used_blocks_o !== exp_res.used_blk) begin
            $error("used_blocks exp %0d got %0d", exp_res.used_blk, used_blocks_o);
            fail_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= idle_en ? ($urandom_range(0, 99) >= 35) : 1'b1;
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Directed rows: typed where the answer is obvious, otherwise predicted
  dir_row_t dir_rows [20];

  initial begin
    dir_rows = '{
      '{ffa_pkg::OP_QUERY, 8'd0,   11'd0,    1'b1,
        '{ffa_pkg::ST_OK,         10'd0, 10'd0,    11'd1024, 11'd0}},
      '{ffa_pkg::OP_ALLOC, 8'd0,   11'd0,    1'b1,
        '{ffa_pkg::ST_BAD_LENGTH, 10'd0, 10'd0,    11'd1024, 11'd0}},
      '{ffa_pkg::OP_ALLOC, 8'd255, 11'd1024, 1'b1,
        '{ffa_pkg::ST_OK,         10'd0, 10'd1023, 11'd0,    11'd1024}},
      '{ffa_pkg::OP_ALLOC, 8'd1,   11'd1,    1'b1,
        '{ffa_pkg::ST_NO_SPACE,   10'd0, 10'd0,    11'd0,    11'd1024}},
      '{ffa_pkg::OP_ALLOC, 8'd255, 11'd5,    1'b1,
        '{ffa_pkg::ST_DUPLICATE,  10'd0, 10'd0,    11'd0,    11'd1024}},
      '{ffa_pkg::OP_FREE,  8'd255, 11'd2047, 1'b1,
        '{ffa_pkg::ST_OK,         10'd0, 10'd1023, 11'd1024, 11'd0}},
      '{ffa_pkg::OP_FREE,  8'd255, 11'd0,    1'b1,
        '{ffa_pkg::ST_NOT_FOUND,  10'd0, 10'd0,    11'd1024, 11'd0}},
      '{OP_SPARE,          8'd170, 11'd1365, 1'b1,
        '{ffa_pkg::ST_OK,         10'd0, 10'd0,    11'd1024, 11'd0}},
      '{ffa_pkg::OP_ALLOC, 8'd10,  11'd2047, 1'b1,
        '{ffa_pkg::ST_NO_SPACE,   10'd0, 10'd0,    11'd1024, 11'd0}},
      '{ffa_pkg::OP_ALLOC, 8'd11,  11'd1,    1'b0, '0},
      '{ffa_pkg::OP_ALLOC, 8'd12,  11'd3,    1'b0, '0},
      '{ffa_pkg::OP_ALLOC, 8'd13,  11'd2,    1'b0, '0},
      '{ffa_pkg::OP_FREE,  8'd12,  11'd0,    1'b0, '0},
      '{ffa_pkg::OP_ALLOC, 8'd14,  11'd2,    1'b0, '0},
      '{ffa_pkg::OP_ALLOC, 8'd15,  11'd2,    1'b0, '0},
      '{ffa_pkg::OP_QUERY, 8'd85,  11'd682,  1'b0, '0},
      '{ffa_pkg::OP_FREE,  8'd11,  11'd0,    1'b0, '0},
      '{ffa_pkg::OP_FREE,  8'd13,  11'd0,    1'b0, '0},
      '{ffa_pkg::OP_FREE,  8'd14,  11'd0,    1'b0, '0},
      '{ffa_pkg::OP_FREE,  8'd15,  11'd0,    1'b0, '0}
    };
    set_disk_size(11'd1024);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      issue_request(dir_rows[i].op, dir_rows[i].file_id, dir_rows[i].length,
                    dir_rows[i].typed, dir_rows[i].want);
    end
    drain_results();

    // small disk, long receiver hold so the input backs up
    write_disk_size(11'd64);
    hold_req = 1'b1;
    random_phase(160, 47, 4);
    drain_results();

    // mostly single-block lengths on 40 blocks fill the file table
    write_disk_size(11'd40);
    random_phase(100, 63, 1);
    drain_results();

    // zero size acts as one block
    write_disk_size(11'd0);
    random_phase(30, 3, 2);
    drain_results();

    // oversize clamps to the full disk; no idling on either side
    idle_en = 1'b0;
    write_disk_size(11'd2047);
    random_phase(40, 255, 64);
    drain_results();
    idle_en = 1'b1;

    write_disk_size(11'd200);
    random_phase(120, 40, 16);
    drain_results();

    write_disk_size(11'd1024);
    random_phase(60, 255, 400);
    drain_results();

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/ffa_pkg.sv
src/ffa_ram.sv
src/first_fit_contiguous_block_allocator_core.sv
tb/tb.sv
